[sv/stek_pkg.sv]
// Shared constants for the surface tension edge kernel.
// Widths of the Q16.16 fields and of the length and unit vector paths.
// No dependencies.
package stek_pkg;

    // Width of every data field on the channels.
    localparam int DATA_W        = 32;
    // Default number of fraction bits of the fixed point format.
    localparam int FRAC_BITS_DEF = 16;
    // Fraction bits of the internal unit vector.
    localparam int UNIT_BITS     = 30;
    // Width of the edge length (square root of a 65-bit sum).
    localparam int LEN_W         = DATA_W + 1;
    // Radicand width, padded to an even number of bits.
    localparam int RAD_W         = 2 * LEN_W;
    // Width of a full 32 by 32 product.
    localparam int PROD_W        = 2 * DATA_W;

endpackage

[sv/stek_ifs.sv]
// Valid/ready channel interfaces for the surface tension edge kernel.
// One beat carries one edge or one result. Depends on stek_pkg.
interface stek_in_if import stek_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] x_first;
    logic signed [DATA_W-1:0] y_first;
    logic signed [DATA_W-1:0] x_second;
    logic signed [DATA_W-1:0] y_second;
    logic signed [DATA_W-1:0] tension_coeff;
    logic        [DATA_W-1:0] ramp_time;
    logic        [DATA_W-1:0] now;

    modport source (output valid, x_first, y_first, x_second, y_second,
                    tension_coeff, ramp_time, now, input ready);
    modport sink   (input valid, x_first, y_first, x_second, y_second,
                    tension_coeff, ramp_time, now, output ready);
endinterface

interface stek_out_if import stek_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] stiff_xx;
    logic signed [DATA_W-1:0] stiff_xy;
    logic signed [DATA_W-1:0] stiff_yy;
    logic                     degenerate;

    modport source (output valid, force_x, force_y, stiff_xx, stiff_xy, stiff_yy,
                    degenerate, input ready);
    modport sink   (input valid, force_x, force_y, stiff_xx, stiff_xy, stiff_yy,
                    degenerate, output ready);
endinterface

[sv/surface_tension_edge_kernel_top.sv]
// Surface tension line element for one 2D boundary edge, fully pipelined.
// Uses stek_pkg, stek_ifs, stek_sqrt_pipe and stek_div_pipe.
//
// Usage:
//   edges   : input channel, one beat per edge (two end points, tension
//             coefficient, ramp time, current time).
//   results : output channel, one beat per edge (force on the first node,
//             the 2x2 stiffness block and the zero length flag).
//   cfg_wr_en / cfg_wr_data : write of the stiffness scale register; write it
//             only while no edge is in flight.
// Throughput: one edge per cycle while no result is held at the output. The
//   pipeline holds the ramp divider (FRAC_BITS stages), the square root (33
//   stages) and two 32-stage dividers, one quotient bit per stage.
// Reset clears every valid bit and sets the stiffness scale to 1.0; no
//   result is presented until an edge has gone through.
// Stall: when a result waits at the output, the pipeline keeps moving as long
//   as its last stage is empty, so new edges are still taken; once the last
//   stage holds a result, the whole pipeline holds and edges.ready drops.
module surface_tension_edge_kernel_top import stek_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    stek_in_if.sink           edges,
    stek_out_if.source        results,
    input  logic              cfg_wr_en,
    input  logic [DATA_W-1:0] cfg_wr_data
);

    localparam logic [DATA_W-1:0] SCALE_RESET = DATA_W'(64'd1 << FRAC_BITS);
    localparam int                RNUM_W      = DATA_W + FRAC_BITS;
    localparam int                UNIT_W      = UNIT_BITS + 1;
    localparam logic [DATA_W-1:0] SAT_POS     = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG     = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic dxneg;
        logic dyneg;
        logic gneg;
        logic deg;
    } sign_t;

    typedef struct packed {
        sign_t             sg;
        logic              full;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] gmag;
    } ramp_tag_t;

    typedef struct packed {
        sign_t             sg;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] gs;
    } sq_tag_t;

    typedef struct packed {
        sign_t             sg;
        logic [DATA_W-1:0] gs;
    } d1_tag_t;

    typedef struct packed {
        sign_t                  sg;
        logic [1:0][DATA_W-1:0] frc;
    } d2_tag_t;

    // Saturate a magnitude with its sign to the signed output range.
    function automatic logic [DATA_W-1:0] sat_q(input logic neg, input logic over,
                                                input logic [DATA_W-1:0] mag);
        logic [DATA_W-1:0] res;
        if (over || mag[DATA_W-1])
        begin
            res = neg ? SAT_NEG : SAT_POS;
        end
        else
        begin
            res = neg ? (~mag + 1'b1) : mag;
        end
        return res;
    endfunction

    logic adv;

    // Stiffness scale register.
    logic [DATA_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            scale_reg <= cfg_wr_data;
        end
    end

    // Input stage: differences, magnitudes, signs and the ramp bypass.
    logic [DATA_W:0]   dx_w;
    logic [DATA_W:0]   dy_w;
    logic [DATA_W-1:0] coeff_u;
    ramp_tag_t         p0_next;
    logic              p0_valid_reg;
    ramp_tag_t         p0_reg;
    logic [DATA_W-1:0] p0_t_reg;
    logic [DATA_W-1:0] p0_t0_reg;

    always_comb
    begin
        dx_w = {edges.x_first[DATA_W-1], edges.x_first}
             - {edges.x_second[DATA_W-1], edges.x_second};
        dy_w = {edges.y_first[DATA_W-1], edges.y_first}
             - {edges.y_second[DATA_W-1], edges.y_second};
        coeff_u          = edges.tension_coeff;
        p0_next.sg.dxneg = dx_w[DATA_W];
        p0_next.sg.dyneg = dy_w[DATA_W];
        p0_next.sg.gneg  = coeff_u[DATA_W-1];
        p0_next.a        = dx_w[DATA_W] ? DATA_W'(-dx_w) : dx_w[DATA_W-1:0];
        p0_next.b        = dy_w[DATA_W] ? DATA_W'(-dy_w) : dy_w[DATA_W-1:0];
        p0_next.sg.deg   = (p0_next.a == '0) && (p0_next.b == '0);
        p0_next.gmag     = coeff_u[DATA_W-1] ? (~coeff_u + 1'b1) : coeff_u;
        p0_next.full     = (edges.ramp_time == '0) || (edges.now >= edges.ramp_time);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p0_valid_reg <= edges.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg    <= p0_next;
            p0_t_reg  <= edges.now;
            p0_t0_reg <= edges.ramp_time;
        end
    end

    // Ramp fraction t / t0 with FRAC_BITS fraction bits.
    logic                 rd_valid;
    logic [FRAC_BITS-1:0] rd_quo;
    ramp_tag_t            rd_tag;

    stek_div_pipe #(
        .NUM_W (RNUM_W),
        .DEN_W (DATA_W),
        .QW    (FRAC_BITS),
        .LANES (1),
        .TAG_W ($bits(ramp_tag_t))
    ) u_ramp_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p0_valid_reg),
        .num       ({p0_t_reg, {FRAC_BITS{1'b0}}}),
        .den       (p0_t0_reg),
        .tag_in    (p0_reg),
        .out_valid (rd_valid),
        .quo       (rd_quo),
        .ovf       (),
        .den_out   (),
        .tag_out   (rd_tag)
    );

    // Ramped coefficient and the two squares.
    logic [RNUM_W-1:0] ramp_prod;
    logic              p1_valid_reg;
    sq_tag_t           p1_reg;
    logic [PROD_W-1:0] p1_sqa_reg;
    logic [PROD_W-1:0] p1_sqb_reg;

    assign ramp_prod = rd_tag.gmag * rd_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= rd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg.sg  <= rd_tag.sg;
            p1_reg.a   <= rd_tag.a;
            p1_reg.b   <= rd_tag.b;
            p1_reg.gs  <= rd_tag.full ? rd_tag.gmag : ramp_prod[RNUM_W-1:FRAC_BITS];
            p1_sqa_reg <= {{DATA_W{1'b0}}, rd_tag.a} * {{DATA_W{1'b0}}, rd_tag.a};
            p1_sqb_reg <= {{DATA_W{1'b0}}, rd_tag.b} * {{DATA_W{1'b0}}, rd_tag.b};
        end
    end

    // Sum of squares.
    logic             p2_valid_reg;
    sq_tag_t          p2_reg;
    logic [RAD_W-1:0] p2_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_reg     <= p1_reg;
            p2_rad_reg <= RAD_W'(p1_sqa_reg) + RAD_W'(p1_sqb_reg);
        end
    end

    // Edge length.
    logic             sq_valid;
    logic [LEN_W-1:0] sq_root;
    sq_tag_t          sq_tag;

    stek_sqrt_pipe #(
        .TAG_W ($bits(sq_tag_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p2_valid_reg),
        .rad       (p2_rad_reg),
        .tag_in    (p2_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .tag_out   (sq_tag)
    );

    // Force numerators and unit vector numerators.
    logic                   p3_valid_reg;
    d1_tag_t                p3_reg;
    logic [LEN_W-1:0]       p3_len_reg;
    logic [3:0][PROD_W-1:0] p3_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p3_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_reg.sg     <= sq_tag.sg;
            p3_reg.gs     <= sq_tag.gs;
            p3_len_reg    <= sq_root;
            p3_num_reg[0] <= {{DATA_W{1'b0}}, sq_tag.gs} * {{DATA_W{1'b0}}, sq_tag.a};
            p3_num_reg[1] <= {{DATA_W{1'b0}}, sq_tag.gs} * {{DATA_W{1'b0}}, sq_tag.b};
            p3_num_reg[2] <= PROD_W'({sq_tag.a, {UNIT_BITS{1'b0}}});
            p3_num_reg[3] <= PROD_W'({sq_tag.b, {UNIT_BITS{1'b0}}});
        end
    end

    // Force magnitudes and unit vector components, divided by the length.
    logic                   d1_valid;
    logic [3:0][DATA_W-1:0] d1_quo;
    logic [LEN_W-1:0]       d1_len;
    d1_tag_t                d1_tag;

    stek_div_pipe #(
        .NUM_W (PROD_W),
        .DEN_W (LEN_W),
        .QW    (DATA_W),
        .LANES (4),
        .TAG_W ($bits(d1_tag_t))
    ) u_len_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p3_valid_reg),
        .num       (p3_num_reg),
        .den       (p3_len_reg),
        .tag_in    (p3_reg),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .ovf       (),
        .den_out   (d1_len),
        .tag_out   (d1_tag)
    );

    // Direction weights from the unit vector: xx, xy, yy.
    logic [UNIT_W-1:0]       ux;
    logic [UNIT_W-1:0]       uy;
    logic [2*UNIT_W-1:0]     w_xx;
    logic [2*UNIT_W-1:0]     w_xy;
    logic [2*UNIT_W-1:0]     w_yy;
    logic                    p4_valid_reg;
    d1_tag_t                 p4_reg;
    logic [LEN_W-1:0]        p4_len_reg;
    logic [1:0][DATA_W-1:0]  p4_frc_reg;
    logic [2:0][UNIT_W-1:0]  p4_m_reg;

    assign ux   = d1_quo[2][UNIT_W-1:0];
    assign uy   = d1_quo[3][UNIT_W-1:0];
    assign w_xx = uy * uy;
    assign w_xy = ux * uy;
    assign w_yy = ux * ux;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p4_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_reg        <= d1_tag;
            p4_len_reg    <= d1_len;
            p4_frc_reg[0] <= d1_quo[0];
            p4_frc_reg[1] <= d1_quo[1];
            p4_m_reg[0]   <= w_xx[UNIT_BITS +: UNIT_W];
            p4_m_reg[1]   <= w_xy[UNIT_BITS +: UNIT_W];
            p4_m_reg[2]   <= w_yy[UNIT_BITS +: UNIT_W];
        end
    end

    // Ramped coefficient times each weight.
    logic [2:0][DATA_W+UNIT_W-1:0] h_prod;
    logic                          p5_valid_reg;
    sign_t                         p5_sg_reg;
    logic [LEN_W-1:0]              p5_len_reg;
    logic [1:0][DATA_W-1:0]        p5_frc_reg;
    logic [2:0][DATA_W-1:0]        p5_h_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            h_prod[k] = p4_reg.gs * p4_m_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_sg_reg  <= p4_reg.sg;
            p5_len_reg <= p4_len_reg;
            p5_frc_reg <= p4_frc_reg;
            for (int k = 0; k < 3; k++)
            begin
                p5_h_reg[k] <= h_prod[k][UNIT_BITS +: DATA_W];
            end
        end
    end

    // Integrator scale.
    logic                   p6_valid_reg;
    d2_tag_t                p6_reg;
    logic [LEN_W-1:0]       p6_len_reg;
    logic [2:0][PROD_W-1:0] p6_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p6_valid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_reg.sg  <= p5_sg_reg;
            p6_reg.frc <= p5_frc_reg;
            p6_len_reg <= p5_len_reg;
            for (int k = 0; k < 3; k++)
            begin
                p6_num_reg[k] <= {{DATA_W{1'b0}}, p5_h_reg[k]} * {{DATA_W{1'b0}}, scale_reg};
            end
        end
    end

    // Stiffness magnitudes, divided by the length.
    logic                   d2_valid;
    logic [2:0][DATA_W-1:0] d2_quo;
    logic [2:0]             d2_ovf;
    d2_tag_t                d2_tag;

    stek_div_pipe #(
        .NUM_W (PROD_W),
        .DEN_W (LEN_W),
        .QW    (DATA_W),
        .LANES (3),
        .TAG_W ($bits(d2_tag_t))
    ) u_stiff_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p6_valid_reg),
        .num       (p6_num_reg),
        .den       (p6_len_reg),
        .tag_in    (p6_reg),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .ovf       (d2_ovf),
        .den_out   (),
        .tag_out   (d2_tag)
    );

    // The pipeline moves unless its last stage holds a beat the output cannot take.
    assign adv         = !d2_valid || !results.valid || results.ready;
    assign edges.ready = adv;

    // Signs, saturation and the zero length override.
    logic              fneg_x;
    logic              fneg_y;
    logic              kneg_xy;
    logic [DATA_W-1:0] fx_next;
    logic [DATA_W-1:0] fy_next;
    logic [DATA_W-1:0] kxx_next;
    logic [DATA_W-1:0] kxy_next;
    logic [DATA_W-1:0] kyy_next;

    always_comb
    begin
        fneg_x   = d2_tag.sg.gneg == d2_tag.sg.dxneg;
        fneg_y   = d2_tag.sg.gneg == d2_tag.sg.dyneg;
        kneg_xy  = d2_tag.sg.gneg != (d2_tag.sg.dxneg == d2_tag.sg.dyneg);
        fx_next  = sat_q(fneg_x, 1'b0, d2_tag.frc[0]);
        fy_next  = sat_q(fneg_y, 1'b0, d2_tag.frc[1]);
        kxx_next = sat_q(d2_tag.sg.gneg, d2_ovf[0], d2_quo[0]);
        kxy_next = sat_q(kneg_xy, d2_ovf[1], d2_quo[1]);
        kyy_next = sat_q(d2_tag.sg.gneg, d2_ovf[2], d2_quo[2]);
        if (d2_tag.sg.deg)
        begin
            fx_next  = '0;
            fy_next  = '0;
            kxx_next = '0;
            kxy_next = '0;
            kyy_next = '0;
        end
    end

    // Output register.
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_fx_reg;
    logic [DATA_W-1:0] out_fy_reg;
    logic [DATA_W-1:0] out_kxx_reg;
    logic [DATA_W-1:0] out_kxy_reg;
    logic [DATA_W-1:0] out_kyy_reg;
    logic              out_deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || results.ready)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || results.ready)
        begin
            out_fx_reg  <= fx_next;
            out_fy_reg  <= fy_next;
            out_kxx_reg <= kxx_next;
            out_kxy_reg <= kxy_next;
            out_kyy_reg <= kyy_next;
            out_deg_reg <= d2_tag.sg.deg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.force_x    = out_fx_reg;
    assign results.force_y    = out_fy_reg;
    assign results.stiff_xx   = out_kxx_reg;
    assign results.stiff_xy   = out_kxy_reg;
    assign results.stiff_yy   = out_kyy_reg;
    assign results.degenerate = out_deg_reg;

    // A zero length beat carries all zero force and stiffness.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.degenerate |->
            results.force_x == '0 && results.force_y == '0 &&
            results.stiff_xx == '0 && results.stiff_xy == '0 && results.stiff_yy == '0)
        else $error("degenerate beat with nonzero payload");

    // Diagonal stiffness entries never carry opposite signs.
    a_diag_sign: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.stiff_xx[DATA_W-1] && results.stiff_yy != '0 |->
            results.stiff_yy[DATA_W-1])
        else $error("diagonal stiffness entries differ in sign");

    // A result blocked at the output keeps the last pipeline stage occupied.
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        d2_valid && results.valid && !results.ready |=> d2_valid)
        else $error("last pipeline stage lost a beat during a stall");

endmodule

[sv/stek_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
// Carries a sideband tag alongside the data. Depends on stek_pkg.
module stek_sqrt_pipe import stek_pkg::*; #(
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [RAD_W-1:0] rad,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [LEN_W-1:0] root,
    output logic [TAG_W-1:0] tag_out
);

    localparam int REM_W = LEN_W + 3;

    logic             v_reg    [LEN_W];
    logic [REM_W-1:0] rem_reg  [LEN_W];
    logic [LEN_W-1:0] root_reg [LEN_W];
    logic [RAD_W-1:0] rad_reg  [LEN_W];
    logic [TAG_W-1:0] tag_reg  [LEN_W];

    for (genvar k = 0; k < LEN_W; k++) begin : g_step
        logic             v_src;
        logic [REM_W-1:0] rem_src;
        logic [LEN_W-1:0] root_src;
        logic [RAD_W-1:0] rad_src;
        logic [TAG_W-1:0] tag_src;
        logic [REM_W-1:0] rem_shift;
        logic [REM_W-1:0] trial;
        logic             ge;

        // The first stage starts from an empty remainder and root.
        if (k == 0) begin : g_head
            assign v_src    = in_valid;
            assign rem_src  = '0;
            assign root_src = '0;
            assign rad_src  = rad;
            assign tag_src  = tag_in;
        end else begin : g_tail
            assign v_src    = v_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign tag_src  = tag_reg[k-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign rem_shift = {rem_src[REM_W-3:0], rad_src[RAD_W-1 -: 2]};
        assign trial     = REM_W'({root_src, 2'b01});
        assign ge        = rem_shift >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? rem_shift - trial : rem_shift;
                root_reg[k] <= {root_src[LEN_W-2:0], ge};
                rad_reg[k]  <= {rad_src[RAD_W-3:0], 2'b00};
                tag_reg[k]  <= tag_src;
            end
        end
    end

    assign out_valid = v_reg[LEN_W-1];
    assign root      = root_reg[LEN_W-1];
    assign tag_out   = tag_reg[LEN_W-1];

endmodule

[sv/stek_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Flags lanes whose quotient does not fit. No dependencies.
module stek_div_pipe #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 33,
    parameter int QW    = 32,
    parameter int LANES = 1,
    parameter int TAG_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]            den,
    input  logic [TAG_W-1:0]            tag_in,
    output logic                        out_valid,
    output logic [LANES-1:0][QW-1:0]    quo,
    output logic [LANES-1:0]            ovf,
    output logic [DEN_W-1:0]            den_out,
    output logic [TAG_W-1:0]            tag_out
);

    localparam int TOP_W = NUM_W - QW;
    localparam int CMP_W = (TOP_W > DEN_W) ? TOP_W : DEN_W;

    logic                        v_reg    [QW];
    logic [DEN_W-1:0]            den_reg  [QW];
    logic [TAG_W-1:0]            tag_reg  [QW];
    logic [LANES-1:0][DEN_W-1:0] rem_reg  [QW];
    logic [LANES-1:0][QW-1:0]    work_reg [QW];
    logic [LANES-1:0]            ovf_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic                        v_src;
        logic [DEN_W-1:0]            den_src;
        logic [TAG_W-1:0]            tag_src;
        logic [LANES-1:0][DEN_W-1:0] rem_src;
        logic [LANES-1:0][QW-1:0]    work_src;
        logic [LANES-1:0]            ovf_src;
        logic [LANES-1:0][DEN_W:0]   rem_shift;
        logic [LANES-1:0]            ge;
        logic [LANES-1:0][DEN_W-1:0] rem_nx;
        logic [LANES-1:0][QW-1:0]    work_nx;

        // The first stage splits the dividend and checks for quotient overflow.
        if (k == 0) begin : g_head
            assign v_src   = in_valid;
            assign den_src = den;
            assign tag_src = tag_in;
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_src[l]  = DEN_W'(num[l] >> QW);
                    work_src[l] = num[l][QW-1:0];
                    ovf_src[l]  = CMP_W'(num[l] >> QW) >= CMP_W'(den);
                end
            end
        end else begin : g_tail
            assign v_src    = v_reg[k-1];
            assign den_src  = den_reg[k-1];
            assign tag_src  = tag_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign work_src = work_reg[k-1];
            assign ovf_src  = ovf_reg[k-1];
        end

        // One compare and subtract per lane; the quotient bit shifts into work.
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rem_shift[l] = {rem_src[l], work_src[l][QW-1]};
                ge[l]        = rem_shift[l] >= {1'b0, den_src};
                rem_nx[l]    = ge[l] ? DEN_W'(rem_shift[l] - {1'b0, den_src})
                                     : DEN_W'(rem_shift[l]);
                work_nx[l]   = {work_src[l][QW-2:0], ge[l]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k]  <= den_src;
                tag_reg[k]  <= tag_src;
                rem_reg[k]  <= rem_nx;
                work_reg[k] <= work_nx;
                ovf_reg[k]  <= ovf_src;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = work_reg[QW-1];
    assign ovf       = ovf_reg[QW-1];
    assign den_out   = den_reg[QW-1];
    assign tag_out   = tag_reg[QW-1];

endmodule

[dv/testbench.sv]
// Self-checking bench for the surface tension edge kernel.
// Drives edges and writes the stiffness scale, then compares every result beat
// with a bit-exact fixed point predictor. Depends on stek_pkg, stek_ifs and the top.
module testbench;
    import stek_pkg::*;

    localparam int LATENCY = FRAC_BITS_DEF + 105;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_first;
        logic signed [DATA_W-1:0] y_first;
        logic signed [DATA_W-1:0] x_second;
        logic signed [DATA_W-1:0] y_second;
        logic signed [DATA_W-1:0] tension_coeff;
        logic [DATA_W-1:0] ramp_time;
        logic [DATA_W-1:0] now;
    } edge_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] force_x;
        logic [DATA_W-1:0] force_y;
        logic [DATA_W-1:0] stiff_xx;
        logic [DATA_W-1:0] stiff_xy;
        logic [DATA_W-1:0] stiff_yy;
        logic degenerate;
    } tension_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en = 1'b0;
    logic [DATA_W-1:0] cfg_wr_data = '0;

    stek_in_if  edges_if ();
    stek_out_if results_if ();

    surface_tension_edge_kernel_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .edges       (edges_if),
        .results     (results_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    edge_beat_t      pending_edges[$];
    tension_result_t expected_results[$];
    logic [DATA_W-1:0] scale_reg = 32'h0001_0000;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  failures = 0;
    int  cycles = 0;
    bit  edge_taken = 0;

    // Saturate a sign and magnitude to the signed 32-bit range.
    function automatic logic [DATA_W-1:0] clamp_q(input bit neg, input logic [127:0] mag);
        if (neg)
            return (mag >= 128'h8000_0000) ? 32'h8000_0000 : DATA_W'(-mag);
        return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : DATA_W'(mag);
    endfunction

    // Edge force and scaled stiffness block for one edge.
    function automatic tension_result_t edge_tension(input edge_beat_t e,
                                                     input logic [DATA_W-1:0] scale);
        tension_result_t res;
        logic signed [DATA_W:0] dx, dy;
        logic [127:0] a, b, sum_sq, len, cand, gmag, ratio, ux, uy, mxx, myy, mxy;
        bit gneg;
        res = '0;
        dx = $signed({e.x_first[DATA_W-1], e.x_first}) - $signed({e.x_second[DATA_W-1], e.x_second});
        dy = $signed({e.y_first[DATA_W-1], e.y_first}) - $signed({e.y_second[DATA_W-1], e.y_second});
        a = dx[DATA_W] ? 128'(-dx) : 128'(dx);
        b = dy[DATA_W] ? 128'(-dy) : 128'(dy);
        a = a & 128'h1_FFFF_FFFF;
        b = b & 128'h1_FFFF_FFFF;
        sum_sq = a * a + b * b;
        len = 0;
        for (int i = 32; i >= 0; i--)
        begin
            cand = len | (128'd1 << i);
            if (cand * cand <= sum_sq)
                len = cand;
        end
        // A zero length edge gives zeros and raises the flag.
        if (len == 0)
        begin
            res.degenerate = 1'b1;
            return res;
        end
        gneg = e.tension_coeff[DATA_W-1];
        gmag = gneg ? 128'(-$signed({e.tension_coeff[DATA_W-1], e.tension_coeff}))
                    : 128'(e.tension_coeff);
        // Ramp the coefficient up over the ramp time.
        if (e.ramp_time != 0)
        begin
            ratio = (e.now >= e.ramp_time) ? (128'd1 << FRAC_BITS_DEF)
                  : ((128'(e.now) << FRAC_BITS_DEF) / 128'(e.ramp_time));
            gmag = (gmag * ratio) >> FRAC_BITS_DEF;
        end
        if (gmag == 0)
            return res;
        res.force_x = (a == 0) ? '0 : clamp_q(gneg == dx[DATA_W], (gmag * a) / len);
        res.force_y = (b == 0) ? '0 : clamp_q(gneg == dy[DATA_W], (gmag * b) / len);
        ux = (a << UNIT_BITS) / len;
        uy = (b << UNIT_BITS) / len;
        mxx = (uy * uy) >> UNIT_BITS;
        myy = (ux * ux) >> UNIT_BITS;
        mxy = (ux * uy) >> UNIT_BITS;
        res.stiff_xx = clamp_q(gneg, (((gmag * mxx) >> UNIT_BITS) * 128'(scale)) / len);
        res.stiff_xy = clamp_q(gneg != (dx[DATA_W] == dy[DATA_W]),
                               (((gmag * mxy) >> UNIT_BITS) * 128'(scale)) / len);
        res.stiff_yy = clamp_q(gneg, (((gmag * myy) >> UNIT_BITS) * 128'(scale)) / len);
        return res;
    endfunction

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        edges_if.valid = 1'b0;
        edges_if.x_first = '0;
        edges_if.y_first = '0;
        edges_if.x_second = '0;
        edges_if.y_second = '0;
        edges_if.tension_coeff = '0;
        edges_if.ramp_time = '0;
        edges_if.now = '0;
        results_if.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Edge driver: holds a beat until it is taken, then moves on or idles.
    always @(negedge clk)
    begin
        edge_beat_t e;
        if (rst_n && (!edges_if.valid || edge_taken))
        begin
            edge_taken = 0;
            if (pending_edges.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                e = pending_edges.pop_front();
                edges_if.x_first <= e.x_first;
                edges_if.y_first <= e.y_first;
                edges_if.x_second <= e.x_second;
                edges_if.y_second <= e.y_second;
                edges_if.tension_coeff <= e.tension_coeff;
                edges_if.ramp_time <= e.ramp_time;
                edges_if.now <= e.now;
                edges_if.valid <= 1'b1;
            end
            else
                edges_if.valid <= 1'b0;
        end
        if (rst_n)
            results_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Monitor: predicts on accepted edges, checks accepted results.
    always @(posedge clk)
    begin
        edge_beat_t e;
        tension_result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            if (edges_if.valid && edges_if.ready)
            begin
                edge_taken = 1;
                e.x_first = edges_if.x_first;
                e.y_first = edges_if.y_first;
                e.x_second = edges_if.x_second;
                e.y_second = edges_if.y_second;
                e.tension_coeff = edges_if.tension_coeff;
                e.ramp_time = edges_if.ramp_time;
                e.now = edges_if.now;
                expected_results.push_back(edge_tension(e, scale_reg));
            end
            if (cfg_wr_en)
                scale_reg = cfg_wr_data;
            if (results_if.valid && results_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no edge outstanding");
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (results_if.force_x !== want.force_x)
                    begin
                        $error("force_x: expected %h, got %h", want.force_x, results_if.force_x);
                        failures++;
                    end
                    if (results_if.force_y !== want.force_y)
                    begin
                        $error("force_y: expected %h, got %h", want.force_y, results_if.force_y);
                        failures++;
                    end
                    if (results_if.stiff_xx !== want.stiff_xx)
                    begin
                        $error("stiff_xx: expected %h, got %h", want.stiff_xx, results_if.stiff_xx);
                        failures++;
                    end
                    if (results_if.stiff_xy !== want.stiff_xy)
                    begin
                        $error("stiff_xy: expected %h, got %h", want.stiff_xy, results_if.stiff_xy);
                        failures++;
                    end
                    if (results_if.stiff_yy !== want.stiff_yy)
                    begin
                        $error("stiff_yy: expected %h, got %h", want.stiff_yy, results_if.stiff_yy);
                        failures++;
                    end
                    if (results_if.degenerate !== want.degenerate)
                    begin
                        $error("degenerate: expected %b, got %b",
                               want.degenerate, results_if.degenerate);
                        failures++;
                    end
                end
            end
        end
    end

    function automatic edge_beat_t mk_edge(input logic [31:0] x1, input logic [31:0] y1,
                                           input logic [31:0] x2, input logic [31:0] y2,
                                           input logic [31:0] g, input logic [31:0] t0,
                                           input logic [31:0] t);
        edge_beat_t e;
        e = '{x1, y1, x2, y2, g, t0, t};
        return e;
    endfunction

    // Coordinate: mostly modest mesh values, sometimes the full range.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
            default: return 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
        endcase
    endfunction

    function automatic edge_beat_t rand_edge();
        edge_beat_t e;
        e.x_first = rand_coord();
        e.y_first = rand_coord();
        e.x_second = e.x_first;
        e.y_second = e.y_first;
        // Zero length edges now and then, axis aligned ones too.
        case ($urandom_range(0, 9))
            0: ;
            1: e.x_second = rand_coord();
            2: e.y_second = rand_coord();
            default:
            begin
                e.x_second = rand_coord();
                e.y_second = rand_coord();
            end
        endcase
        case ($urandom_range(0, 9))
            0: e.tension_coeff = '0;
            1, 2: e.tension_coeff = $urandom();
            default: e.tension_coeff = 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
        case ($urandom_range(0, 3))
            0: e.ramp_time = '0;
            1: e.ramp_time = $urandom();
            default: e.ramp_time = $urandom_range(1, 32'h000A_0000);
        endcase
        case ($urandom_range(0, 3))
            0: e.now = $urandom();
            1: e.now = '0;
            default: e.now = $urandom_range(0, 32'h000C_0000);
        endcase
        return e;
    endfunction

    // Let the pipeline drain completely; checked at clock edges so that a beat
    // just popped by the driver is already visible on valid.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_edges.size() != 0 || edges_if.valid || expected_results.size() != 0);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_scale(input logic [DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Test sequence: directed edges, then random phases over scale settings.
    initial
    begin
        logic [DATA_W-1:0] scales[5];
        int idle_mix[4][2];
        scales = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0003_8000, 32'h0000_0001};
        idle_mix = '{'{0, 0}, '{46, 0}, '{0, 46}, '{27, 27}};
        wait (rst_n === 1'b1);
        // Directed: reset scale, extremes and every special case.
        pending_edges.push_back(mk_edge(0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 0, 0));
        pending_edges.push_back(mk_edge(5, 7, 5, 7, 32'h0001_0000, 0, 0));
        pending_edges.push_back(mk_edge(5, 7, 5, 7, 0, 0, 0));
        pending_edges.push_back(mk_edge(0, 0, 32'h0001_0000, 0, 0, 0, 0));
        pending_edges.push_back(mk_edge(0, 0, 32'h0001_0000, 0, 32'h0002_0000, 32'h0001_0000, 0));
        pending_edges.push_back(mk_edge(0, 0, 0, 32'h0001_0000, 32'hFFFE_0000, 32'h0002_0000,
                                        32'h0001_0000));
        pending_edges.push_back(mk_edge(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000,
                                        32'h0002_0000));
        pending_edges.push_back(mk_edge(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFE));
        pending_edges.push_back(mk_edge(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h8000_0000, 32'h7FFF_FFFF, 0, 0));
        pending_edges.push_back(mk_edge(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        pending_edges.push_back(mk_edge(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000,
                                        0, 0));
        pending_edges.push_back(mk_edge(0, 0, 1, 0, 32'h7FFF_FFFF, 0, 0));
        pending_edges.push_back(mk_edge(0, 0, 1, 1, 32'h8000_0000, 0, 0));
        pending_edges.push_back(mk_edge(1, 0, 0, 1, 32'h0001_0000, 0, 0));
        pending_edges.push_back(mk_edge(0, 1, 1, 0, 32'hFFFF_0000, 0, 0));
        pending_edges.push_back(mk_edge(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'h0000_0001, 0, 0));
        pending_edges.push_back(mk_edge(0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0000_0001,
                                        32'hFFFF_FFFF, 32'h0000_0001));
        drain();
        // Random phases, each at its own scale and idle mix.
        for (int p = 0; p < 5; p++)
        begin
            write_scale(scales[p]);
            for (int k = 0; k < 4; k++)
            begin
                send_idle_pct = idle_mix[k][0];
                stall_pct = idle_mix[k][1];
                for (int n = 0; n < 27; n++)
                    pending_edges.push_back(rand_edge());
                wait (pending_edges.size() == 0);
            end
            drain();
        end
        send_idle_pct = 0;
        stall_pct = 0;
        drain();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
